[hdl/bpp_pkg.sv]
// bpp_pkg: shared widths, transaction payload types, config register codes
// and saturation helper for the boris particle pusher
// no dependencies
package bpp_pkg;

    localparam int POS_W     = 32;
    localparam int VEL_W     = 32;
    localparam int SL_W      = 31;
    localparam int PSTEP_W   = 32;
    localparam int CELL_W    = 6;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int GRID_CELLS_DEF = 64;

    localparam logic [SL_W-1:0]    SPEED_LIMIT_RST   = 31'd107374182;
    localparam logic [PSTEP_W-1:0] POSITION_STEP_RST = 32'd643950;

    // square root unit
    localparam int SQ_RAD_W  = 64;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    // wide signed range used ahead of a saturation
    localparam int WIDE_W = 40;
    localparam logic signed [WIDE_W-1:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -40'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT   = 1'b0,
        CFG_POSITION_STEP = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        [POS_W-1:0] pos_x;
        logic        [POS_W-1:0] pos_y;
        logic        [POS_W-1:0] pos_z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic signed [VEL_W-1:0] kick_x;
        logic signed [VEL_W-1:0] kick_y;
        logic signed [VEL_W-1:0] kick_z;
        logic signed [VEL_W-1:0] rot_x;
        logic signed [VEL_W-1:0] rot_y;
        logic signed [VEL_W-1:0] rot_z;
    } t_in_item;

    typedef struct packed {
        logic        [POS_W-1:0]  new_pos_x;
        logic        [POS_W-1:0]  new_pos_y;
        logic        [POS_W-1:0]  new_pos_z;
        logic signed [VEL_W-1:0]  new_vel_x;
        logic signed [VEL_W-1:0]  new_vel_y;
        logic signed [VEL_W-1:0]  new_vel_z;
        logic                     speed_clipped;
        logic        [CELL_W-1:0] cell_x;
        logic        [CELL_W-1:0] cell_y;
        logic        [CELL_W-1:0] cell_z;
    } t_out_item;

    // clamp to the signed 32 bit range
    function automatic logic signed [VEL_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > SAT_MAX) begin
            return SAT_MAX[VEL_W-1:0];
        end else if (x < SAT_MIN) begin
            return SAT_MIN[VEL_W-1:0];
        end
        return x[VEL_W-1:0];
    endfunction

endpackage

[hdl/bpp_div.sv]
// bpp_div: pipelined restoring divider, one quotient bit per stage,
// several numerators over one shared denominator, side data carried along
// depends on nothing
module bpp_div #(
    parameter int LANES = 1,
    parameter int NW    = 62,
    parameter int DW    = 35,
    parameter int QW    = 32,
    parameter int PW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [LANES-1:0][NW-1:0]    i_num,
    input  logic [DW-1:0]               i_den,
    input  logic [PW-1:0]               i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][QW-1:0]    o_quo,
    output logic [PW-1:0]               o_side
);

    logic                     w_vld  [QW+1];
    logic [LANES-1:0][DW-1:0] w_rem  [QW+1];
    logic [LANES-1:0][QW-1:0] w_low  [QW+1];
    logic [LANES-1:0][QW-1:0] w_quo  [QW+1];
    logic [DW-1:0]            w_den  [QW+1];
    logic [PW-1:0]            w_side [QW+1];

    // leading numerator bits start as the partial remainder
    always_comb begin
        w_vld[0]  = i_vld;
        w_den[0]  = i_den;
        w_side[0] = i_side;
        for (int l = 0; l < LANES; l++) begin
            w_rem[0][l] = DW'(i_num[l][NW-1:QW]);
            w_low[0][l] = i_num[l][QW-1:0];
            w_quo[0][l] = '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                     r_vld;
        logic [LANES-1:0][DW-1:0] r_rem;
        logic [LANES-1:0][QW-1:0] r_low;
        logic [LANES-1:0][QW-1:0] r_quo;
        logic [DW-1:0]            r_den;
        logic [PW-1:0]            r_side;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_low;
        logic [LANES-1:0][QW-1:0] n_quo;

        always_comb begin
            logic [DW:0] trial;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                trial    = {w_rem[k][l], w_low[k][l][QW-1]};
                ge       = trial >= {1'b0, w_den[k]};
                n_rem[l] = ge ? DW'(trial - {1'b0, w_den[k]}) : trial[DW-1:0];
                n_low[l] = {w_low[k][l][QW-2:0], 1'b0};
                n_quo[l] = {w_quo[k][l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_low  <= n_low;
                r_quo  <= n_quo;
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_vld[k+1]  = r_vld;
        assign w_rem[k+1]  = r_rem;
        assign w_low[k+1]  = r_low;
        assign w_quo[k+1]  = r_quo;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
    end

    assign o_vld  = w_vld[QW];
    assign o_quo  = w_quo[QW];
    assign o_side = w_side[QW];

endmodule

[hdl/bpp_isqrt.sv]
// bpp_isqrt: pipelined integer square root, one root bit per stage
// depends on bpp_pkg
module bpp_isqrt #(
    parameter int PW = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [bpp_pkg::SQ_RAD_W-1:0]   i_rad,
    input  logic [PW-1:0]                  i_side,
    output logic                           o_vld,
    output logic [bpp_pkg::SQ_ROOT_W-1:0]  o_root,
    output logic [PW-1:0]                  o_side
);
    import bpp_pkg::*;

    localparam int STEPS = SQ_ROOT_W;

    logic                 w_vld  [STEPS+1];
    logic [SQ_REM_W-1:0]  w_rem  [STEPS+1];
    logic [SQ_RAD_W-1:0]  w_rad  [STEPS+1];
    logic [SQ_ROOT_W-1:0] w_root [STEPS+1];
    logic [PW-1:0]        w_side [STEPS+1];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_rad[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic                 r_vld;
        logic [SQ_REM_W-1:0]  r_rem;
        logic [SQ_RAD_W-1:0]  r_rad;
        logic [SQ_ROOT_W-1:0] r_root;
        logic [PW-1:0]        r_side;
        logic [SQ_REM_W+1:0]  w_tmp;
        logic [SQ_REM_W+1:0]  w_trial;
        logic                 w_ge;

        // bring down two radicand bits, try root*4+1
        assign w_tmp   = {w_rem[k], w_rad[k][SQ_RAD_W-1 -: 2]};
        assign w_trial = {2'b00, w_root[k], 2'b01};
        assign w_ge    = w_tmp >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? SQ_REM_W'(w_tmp - w_trial) : w_tmp[SQ_REM_W-1:0];
                r_rad  <= {w_rad[k][SQ_RAD_W-3:0], 2'b00};
                r_root <= {w_root[k][SQ_ROOT_W-2:0], w_ge};
                r_side <= w_side[k];
            end
        end

        assign w_vld[k+1]  = r_vld;
        assign w_rem[k+1]  = r_rem;
        assign w_rad[k+1]  = r_rad;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_vld  = w_vld[STEPS];
    assign o_root = w_root[STEPS];
    assign o_side = w_side[STEPS];

endmodule

[hdl/boris_particle_pusher_top.sv]
// boris_particle_pusher_top: throughput one transaction per cycle while the
// output buffer has room; the two restoring dividers (32 and 31
// stages) and the 32 stage square root set the depth, every stage is one step
// a two entry output buffer lets one more transaction in while a result waits
// synchronous active low reset clears all valid bits and loads config defaults
// depends on bpp_pkg, bpp_div, bpp_isqrt
module boris_particle_pusher_top #(
    parameter int GRID_CELLS = bpp_pkg::GRID_CELLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bpp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bpp_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bpp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpp_pkg::CFG_W-1:0]     i_cfg_data
);
    import bpp_pkg::*;

    typedef logic signed [2:0][VEL_W-1:0] t_vvec;
    typedef logic        [2:0][POS_W-1:0] t_pvec;

    // side data through the s divider
    typedef struct packed {
        t_pvec pos;
        t_vvec vm;
        t_vvec kick;
        t_vvec c2;
    } t_rot_side;

    // side data through the square root and the limiter divider
    typedef struct packed {
        t_pvec pos;
        t_vvec v;
        logic  clip;
    } t_lim_side;

    localparam int DEN_S_W = 35;
    localparam int NUM_S_W = 62;
    localparam int Q_S_W   = 32;
    localparam logic [NUM_S_W-1:0] NUM_S = NUM_S_W'(1) << (NUM_S_W - 1);
    localparam int NUM_L_W = VEL_W + SL_W;
    localparam int Q_L_W   = SL_W;
    localparam int GC_W    = $clog2(GRID_CELLS + 1);
    localparam int CPROD_W = POS_W + ((GC_W > CELL_W) ? GC_W : CELL_W);

    // ---------------------------------------------------------------
    // config registers
    // ---------------------------------------------------------------
    logic [SL_W-1:0]    r_speed_limit;
    logic [PSTEP_W-1:0] r_position_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit   <= SPEED_LIMIT_RST;
            r_position_step <= POSITION_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_data[SL_W-1:0];
                CFG_POSITION_STEP: r_position_step <= i_cfg_data[PSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // global advance: the whole pipe moves unless the output buffer is full
    // ---------------------------------------------------------------
    logic r_o0_vld, r_o1_vld;
    logic w_en;
    assign w_en       = !r_o1_vld;
    assign o_in_ready = w_en;

    // ---------------------------------------------------------------
    // stage 1: first half kick, squares of the rotation vector
    // ---------------------------------------------------------------
    t_pvec w_in_pos;
    t_vvec w_in_v, w_in_k, w_in_t;
    assign w_in_pos = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
    assign w_in_v   = {i_in_data.vel_z, i_in_data.vel_y, i_in_data.vel_x};
    assign w_in_k   = {i_in_data.kick_z, i_in_data.kick_y, i_in_data.kick_x};
    assign w_in_t   = {i_in_data.rot_z, i_in_data.rot_y, i_in_data.rot_x};

    logic               r1_vld;
    t_pvec              r1_pos;
    t_vvec              r1_vm, r1_kick, r1_t;
    logic [2:0][62:0]   r1_tsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] sq;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                sq         = $signed(w_in_t[i]) * $signed(w_in_t[i]);
                r1_tsq[i] <= sq[62:0];
                r1_vm[i]  <= sat32(WIDE_W'($signed(w_in_v[i])) + WIDE_W'($signed(w_in_k[i])));
            end
            r1_pos  <= w_in_pos;
            r1_kick <= w_in_k;
            r1_t    <= w_in_t;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: |t|^2 and the first cross product terms (vm x t)
    // ---------------------------------------------------------------
    logic                      r2_vld;
    t_pvec                     r2_pos;
    t_vvec                     r2_vm, r2_kick, r2_t;
    logic [33:0]               r2_t2;
    logic signed [2:0][63:0]   r2_pa, r2_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] sum;
        if (w_en) begin
            sum      = 64'(r1_tsq[0]) + 64'(r1_tsq[1]) + 64'(r1_tsq[2]);
            r2_t2   <= sum[63:30];
            r2_pa[0] <= $signed(r1_vm[1]) * $signed(r1_t[2]);
            r2_pb[0] <= $signed(r1_vm[2]) * $signed(r1_t[1]);
            r2_pa[1] <= $signed(r1_vm[2]) * $signed(r1_t[0]);
            r2_pb[1] <= $signed(r1_vm[0]) * $signed(r1_t[2]);
            r2_pa[2] <= $signed(r1_vm[0]) * $signed(r1_t[1]);
            r2_pb[2] <= $signed(r1_vm[1]) * $signed(r1_t[0]);
            r2_pos  <= r1_pos;
            r2_vm   <= r1_vm;
            r2_kick <= r1_kick;
            r2_t    <= r1_t;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: v' = vm + vm x t (floor each term, saturate)
    // ---------------------------------------------------------------
    logic        r3_vld;
    t_pvec       r3_pos;
    t_vvec       r3_vm, r3_kick, r3_t, r3_vp;
    logic [33:0] r3_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [VEL_W-1:0] c1;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                c1 = sat32(WIDE_W'($signed(r2_pa[i]) >>> 30)
                         - WIDE_W'($signed(r2_pb[i]) >>> 30));
                r3_vp[i] <= sat32(WIDE_W'($signed(r2_vm[i])) + WIDE_W'(c1));
            end
            r3_pos  <= r2_pos;
            r3_vm   <= r2_vm;
            r3_kick <= r2_kick;
            r3_t    <= r2_t;
            r3_t2   <= r2_t2;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: second cross product terms (v' x t)
    // ---------------------------------------------------------------
    logic                    r4_vld;
    t_pvec                   r4_pos;
    t_vvec                   r4_vm, r4_kick;
    logic [33:0]             r4_t2;
    logic signed [2:0][63:0] r4_pa, r4_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pa[0] <= $signed(r3_vp[1]) * $signed(r3_t[2]);
            r4_pb[0] <= $signed(r3_vp[2]) * $signed(r3_t[1]);
            r4_pa[1] <= $signed(r3_vp[2]) * $signed(r3_t[0]);
            r4_pb[1] <= $signed(r3_vp[0]) * $signed(r3_t[2]);
            r4_pa[2] <= $signed(r3_vp[0]) * $signed(r3_t[1]);
            r4_pb[2] <= $signed(r3_vp[1]) * $signed(r3_t[0]);
            r4_pos  <= r3_pos;
            r4_vm   <= r3_vm;
            r4_kick <= r3_kick;
            r4_t2   <= r3_t2;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: c = sat(v' x t), divisor 1 + |t|^2
    // ---------------------------------------------------------------
    logic               r5_vld;
    t_rot_side          r5_side;
    logic [DEN_S_W-1:0] r5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_side.c2[i] <= sat32(WIDE_W'($signed(r4_pa[i]) >>> 30)
                                     - WIDE_W'($signed(r4_pb[i]) >>> 30));
            end
            r5_side.pos  <= r4_pos;
            r5_side.vm   <= r4_vm;
            r5_side.kick <= r4_kick;
            r5_den       <= DEN_S_W'(r4_t2) + (DEN_S_W'(1) << 30);
        end
    end

    // ---------------------------------------------------------------
    // s = 2 / (1 + |t|^2) in Q.30
    // ---------------------------------------------------------------
    logic                    w_ds_vld;
    logic [0:0][Q_S_W-1:0]   w_ds_quo;
    t_rot_side               w_ds_side;

    bpp_div #(
        .LANES (1),
        .NW    (NUM_S_W),
        .DW    (DEN_S_W),
        .QW    (Q_S_W),
        .PW    ($bits(t_rot_side))
    ) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r5_vld),
        .i_num   (NUM_S),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_vld   (w_ds_vld),
        .o_quo   (w_ds_quo),
        .o_side  (w_ds_side)
    );

    // ---------------------------------------------------------------
    // stage 6: c * s
    // ---------------------------------------------------------------
    logic                    r6_vld;
    t_pvec                   r6_pos;
    t_vvec                   r6_vm, r6_kick;
    logic signed [2:0][64:0] r6_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= w_ds_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_rp[i] <= $signed(w_ds_side.c2[i]) * $signed({1'b0, w_ds_quo[0]});
            end
            r6_pos  <= w_ds_side.pos;
            r6_vm   <= w_ds_side.vm;
            r6_kick <= w_ds_side.kick;
        end
    end

    // ---------------------------------------------------------------
    // stage 7: v+ = vm + rot, then the second half kick
    // ---------------------------------------------------------------
    logic  r7_vld;
    t_pvec r7_pos;
    t_vvec r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [VEL_W-1:0] vplus;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                vplus   = sat32(WIDE_W'($signed(r6_vm[i])) + WIDE_W'($signed(r6_rp[i]) >>> 30));
                r7_v[i] <= sat32(WIDE_W'(vplus) + WIDE_W'($signed(r6_kick[i])));
            end
            r7_pos <= r6_pos;
        end
    end

    // ---------------------------------------------------------------
    // stage 8: squared components and squared limit
    // ---------------------------------------------------------------
    logic               r8_vld;
    t_pvec              r8_pos;
    t_vvec              r8_v;
    logic [2:0][62:0]   r8_sq;
    logic [2*SL_W-1:0]  r8_lim2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] sq;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                sq        = $signed(r7_v[i]) * $signed(r7_v[i]);
                r8_sq[i] <= sq[62:0];
            end
            r8_lim2 <= (2*SL_W)'(r_speed_limit) * (2*SL_W)'(r_speed_limit);
            r8_pos  <= r7_pos;
            r8_v    <= r7_v;
        end
    end

    // ---------------------------------------------------------------
    // stage 9: |v|^2 against the limit
    // ---------------------------------------------------------------
    logic                r9_vld;
    logic [SQ_RAD_W-1:0] r9_m2;
    t_lim_side           r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (w_en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [SQ_RAD_W-1:0] m2;
        if (w_en) begin
            m2            = SQ_RAD_W'(r8_sq[0]) + SQ_RAD_W'(r8_sq[1]) + SQ_RAD_W'(r8_sq[2]);
            r9_m2        <= m2;
            r9_side.clip <= m2 > SQ_RAD_W'(r8_lim2);
            r9_side.pos  <= r8_pos;
            r9_side.v    <= r8_v;
        end
    end

    // ---------------------------------------------------------------
    // speed magnitude
    // ---------------------------------------------------------------
    logic                 w_sq_vld;
    logic [SQ_ROOT_W-1:0] w_sq_root;
    t_lim_side            w_sq_side;

    bpp_isqrt #(
        .PW ($bits(t_lim_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r9_vld),
        .i_rad   (r9_m2),
        .i_side  (r9_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // ---------------------------------------------------------------
    // stage 10: per component |v_i| * speed_limit for the rescale divide
    // ---------------------------------------------------------------
    logic                       r10_vld;
    logic [2:0][NUM_L_W-1:0]    r10_num;
    logic [SQ_ROOT_W-1:0]       r10_mag;
    t_lim_side                  r10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r10_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [VEL_W-1:0] mag_c;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                mag_c = w_sq_side.v[i][VEL_W-1] ? VEL_W'(-$signed(w_sq_side.v[i]))
                                                : w_sq_side.v[i];
                r10_num[i] <= NUM_L_W'(mag_c) * NUM_L_W'(r_speed_limit);
            end
            r10_mag  <= w_sq_root;
            r10_side <= w_sq_side;
        end
    end

    // ---------------------------------------------------------------
    // rescale: |v| * limit / magnitude, three lanes on one divisor
    // ---------------------------------------------------------------
    logic                  w_dl_vld;
    logic [2:0][Q_L_W-1:0] w_dl_quo;
    t_lim_side             w_dl_side;

    bpp_div #(
        .LANES (3),
        .NW    (NUM_L_W),
        .DW    (SQ_ROOT_W),
        .QW    (Q_L_W),
        .PW    ($bits(t_lim_side))
    ) u_div_lim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r10_vld),
        .i_num   (r10_num),
        .i_den   (r10_mag),
        .i_side  (r10_side),
        .o_vld   (w_dl_vld),
        .o_quo   (w_dl_quo),
        .o_side  (w_dl_side)
    );

    // ---------------------------------------------------------------
    // stage 11: pick limited velocity, scale by position step
    // ---------------------------------------------------------------
    logic                    r11_vld;
    t_pvec                   r11_pos;
    t_vvec                   r11_v;
    logic                    r11_clip;
    logic signed [2:0][64:0] r11_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (w_en) begin
            r11_vld <= w_dl_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [VEL_W-1:0] vf;
        logic signed [VEL_W-1:0] mag_q;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                mag_q = $signed(VEL_W'(w_dl_quo[i]));
                if (!w_dl_side.clip) begin
                    vf = w_dl_side.v[i];
                end else if (w_dl_side.v[i][VEL_W-1]) begin
                    vf = -mag_q;
                end else begin
                    vf = mag_q;
                end
                r11_v[i]  <= vf;
                r11_pd[i] <= vf * $signed({1'b0, r_position_step});
            end
            r11_pos  <= w_dl_side.pos;
            r11_clip <= w_dl_side.clip;
        end
    end

    // ---------------------------------------------------------------
    // final: position advance with wrap, grid cell
    // ---------------------------------------------------------------
    t_out_item         w_res;
    logic [2:0][POS_W-1:0]  w_np;
    logic [2:0][CELL_W-1:0] w_cell;

    always_comb begin
        logic signed [64:0]   d;
        logic [CPROD_W-1:0]   cp;
        for (int i = 0; i < 3; i++) begin
            d         = r11_pd[i] >>> 30;
            w_np[i]   = r11_pos[i] + d[POS_W-1:0];
            cp        = CPROD_W'(w_np[i]) * CPROD_W'(GRID_CELLS);
            w_cell[i] = cp[POS_W +: CELL_W];
        end
        w_res.new_pos_x     = w_np[0];
        w_res.new_pos_y     = w_np[1];
        w_res.new_pos_z     = w_np[2];
        w_res.new_vel_x     = r11_v[0];
        w_res.new_vel_y     = r11_v[1];
        w_res.new_vel_z     = r11_v[2];
        w_res.speed_clipped = r11_clip;
        w_res.cell_x        = w_cell[0];
        w_res.cell_y        = w_cell[1];
        w_res.cell_z        = w_cell[2];
    end

    // ---------------------------------------------------------------
    // two entry output buffer; head drives the port
    // ---------------------------------------------------------------
    t_out_item r_o0, r_o1;
    logic      w_push, w_pop;
    assign w_push = w_en && r11_vld;
    assign w_pop  = r_o0_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o0_vld <= 1'b0;
            r_o1_vld <= 1'b0;
        end else if (w_pop) begin
            // second entry moves up; it is only full when nothing is pushed
            if (r_o1_vld) begin
                r_o1_vld <= 1'b0;
            end else begin
                r_o0_vld <= w_push;
            end
        end else if (!r_o0_vld) begin
            r_o0_vld <= w_push;
        end else if (w_push) begin
            r_o1_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_o0 <= r_o1_vld ? r_o1 : w_res;
        end else if (!r_o0_vld) begin
            r_o0 <= w_res;
        end else if (w_push) begin
            r_o1 <= w_res;
        end
    end

    assign o_out_valid = r_o0_vld;
    assign o_out_data  = r_o0;

endmodule

[hdl/bpp_checker.sv]
// bpp_checker: port level checks for the boris particle pusher
// depends on bpp_pkg; bound to boris_particle_pusher_top below
module bpp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input bpp_pkg::t_in_item             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input bpp_pkg::t_out_item            o_out_data
);
    import bpp_pkg::*;

    // a stalled input transaction stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while stalled");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present after reset");

    // input only backs up when a result is waiting
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // a limited velocity stays inside the 31 bit limit
    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.speed_clipped |->
            o_out_data.new_vel_x != 32'sh80000000 &&
            o_out_data.new_vel_y != 32'sh80000000 &&
            o_out_data.new_vel_z != 32'sh80000000)
        else $error("limited velocity out of range");

endmodule

bind boris_particle_pusher_top bpp_checker u_bpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/tb.sv]
// tb: self-checking testbench for boris_particle_pusher_top, holds a bit exact
// boris push predictor, a valid/ready driver, a result checker and a watchdog
// depends on bpp_pkg and the boris_particle_pusher_top rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpp_pkg::*;

    localparam int RST_CYCLES    = 7;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 130;
    localparam int ITEMS_PER_RUN = 580;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    // predictor copy of the config registers
    longint unsigned   limit_q;
    longint unsigned   step_q;

    t_out_item         pushed_q[$];
    int                in_idle_pct;
    int                out_idle_pct;
    int                n_errors;
    int                n_sent;
    int                n_checked;
    int                n_clipped;
    int                n_cfg;
    int                quiet_cycles;

    boris_particle_pusher_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // boris push predictor
    // ---------------------------------------------------------------

    // clamp to the signed 32 bit range
    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // q1.30 product, floored
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) begin
            bit_w = bit_w >> 2;
        end
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // saturated cross product a x t, each term floored on its own
    function automatic void cross_rot(input longint a[3], input longint t[3],
                                      output longint r[3]);
        r[0] = clamp32(qmul(a[1], t[2]) - qmul(a[2], t[1]));
        r[1] = clamp32(qmul(a[2], t[0]) - qmul(a[0], t[2]));
        r[2] = clamp32(qmul(a[0], t[1]) - qmul(a[1], t[0]));
    endfunction

    function automatic t_out_item push_particle(t_in_item p);
        longint            vel[3];
        longint            kick[3];
        longint            rot[3];
        longint            vm[3];
        longint            vp[3];
        longint            cr[3];
        longint unsigned   pos[3];
        longint unsigned   t2;
        longint unsigned   s_fac;
        longint unsigned   m2;
        longint unsigned   mag;
        longint unsigned   mag_a;
        longint unsigned   scaled;
        logic signed [79:0] delta;
        logic [31:0]       np[3];
        logic              clip;
        t_out_item         o;
        pos[0]  = p.pos_x;
        pos[1]  = p.pos_y;
        pos[2]  = p.pos_z;
        vel[0]  = longint'($signed(p.vel_x));
        vel[1]  = longint'($signed(p.vel_y));
        vel[2]  = longint'($signed(p.vel_z));
        kick[0] = longint'($signed(p.kick_x));
        kick[1] = longint'($signed(p.kick_y));
        kick[2] = longint'($signed(p.kick_z));
        rot[0]  = longint'($signed(p.rot_x));
        rot[1]  = longint'($signed(p.rot_y));
        rot[2]  = longint'($signed(p.rot_z));
        t2 = 0;
        m2 = 0;
        for (int i = 0; i < 3; i++) begin
            vm[i] = clamp32(vel[i] + kick[i]);
            t2 += longint'(rot[i] * rot[i]);
        end
        t2    = t2 >> 30;
        s_fac = (64'd1 << 61) / ((64'd1 << 30) + t2);
        cross_rot(vm, rot, cr);
        for (int i = 0; i < 3; i++) begin
            vp[i] = clamp32(vm[i] + cr[i]);
        end
        cross_rot(vp, rot, cr);
        for (int i = 0; i < 3; i++) begin
            vel[i] = clamp32(clamp32(vm[i] + ((cr[i] * longint'(s_fac)) >>> 30)) + kick[i]);
            m2 += longint'(vel[i] * vel[i]);
        end
        // speed limiter
        clip = 1'b0;
        if (m2 > limit_q * limit_q) begin
            clip = 1'b1;
            mag  = floor_sqrt(m2);
            for (int i = 0; i < 3; i++) begin
                mag_a  = (vel[i] < 0) ? -vel[i] : vel[i];
                scaled = (mag_a * limit_q) / mag;
                vel[i] = (vel[i] < 0) ? -longint'(scaled) : longint'(scaled);
            end
        end
        // advance and wrap
        for (int i = 0; i < 3; i++) begin
            delta = (80'(vel[i]) * $signed({16'd0, step_q})) >>> 30;
            np[i] = pos[i][31:0] + delta[31:0];
        end
        o.new_pos_x     = np[0];
        o.new_pos_y     = np[1];
        o.new_pos_z     = np[2];
        o.new_vel_x     = vel[0][31:0];
        o.new_vel_y     = vel[1][31:0];
        o.new_vel_z     = vel[2][31:0];
        o.speed_clipped = clip;
        o.cell_x        = np[0][31:26];
        o.cell_y        = np[1][31:26];
        o.cell_z        = np[2][31:26];
        return o;
    endfunction

    // ---------------------------------------------------------------
    // driving and checking
    // ---------------------------------------------------------------

    // send one particle, idling first at the current rate
    task automatic send_particle(t_in_item p);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pushed_q.insert(pushed_q.size(), push_particle(p));
        n_sent++;
    endtask

    // drop valid and wait until every pushed particle has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pushed_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // register write, only called while the pipe is drained
    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_SPEED_LIMIT) begin
            limit_q = value[SL_W-1:0];
        end else begin
            step_q = value;
        end
        n_cfg++;
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_v);
        $display("mismatch %s on result %0d: got %h, expected %h",
                 field, n_checked, got, exp_v);
        n_errors++;
    endtask

    // out_ready toggles at the falling edge at the current stall rate
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // result checker: compare each result transaction to the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pushed_q.size() == 0) begin
                $display("unexpected result transaction %0d", n_checked);
                n_errors++;
            end else begin
                want = pushed_q.pop_front();
                if (o_out_data.new_pos_x != want.new_pos_x)
                    report_mismatch("new_pos_x", o_out_data.new_pos_x, want.new_pos_x);
                if (o_out_data.new_pos_y != want.new_pos_y)
                    report_mismatch("new_pos_y", o_out_data.new_pos_y, want.new_pos_y);
                if (o_out_data.new_pos_z != want.new_pos_z)
                    report_mismatch("new_pos_z", o_out_data.new_pos_z, want.new_pos_z);
                if (o_out_data.new_vel_x != want.new_vel_x)
                    report_mismatch("new_vel_x", o_out_data.new_vel_x, want.new_vel_x);
                if (o_out_data.new_vel_y != want.new_vel_y)
                    report_mismatch("new_vel_y", o_out_data.new_vel_y, want.new_vel_y);
                if (o_out_data.new_vel_z != want.new_vel_z)
                    report_mismatch("new_vel_z", o_out_data.new_vel_z, want.new_vel_z);
                if (o_out_data.speed_clipped !== want.speed_clipped)
                    report_mismatch("speed_clipped", 32'(o_out_data.speed_clipped),
                                    32'(want.speed_clipped));
                if (o_out_data.cell_x != want.cell_x)
                    report_mismatch("cell_x", 32'(o_out_data.cell_x), 32'(want.cell_x));
                if (o_out_data.cell_y != want.cell_y)
                    report_mismatch("cell_y", 32'(o_out_data.cell_y), 32'(want.cell_y));
                if (o_out_data.cell_z != want.cell_z)
                    report_mismatch("cell_z", 32'(o_out_data.cell_z), 32'(want.cell_z));
                n_clipped += want.speed_clipped;
            end
            n_checked++;
        end
    end

    // watchdog: cycles in which neither side moves a transaction and no register is written
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles with no transaction", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic logic [31:0] rand_small(int unsigned span);
        return $urandom_range(2 * span) - span;
    endfunction

    // well-formed particles mostly, full range noise for the rest
    function automatic t_in_item rand_particle();
        t_in_item p;
        int unsigned kind;
        kind = $urandom_range(9);
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        if (kind < 6) begin
            // physical: modest speeds, kicks and rotations
            p.vel_x  = rand_small(1 << 28);
            p.vel_y  = rand_small(1 << 28);
            p.vel_z  = rand_small(1 << 28);
            p.kick_x = rand_small(1 << 24);
            p.kick_y = rand_small(1 << 24);
            p.kick_z = rand_small(1 << 24);
            p.rot_x  = rand_small(1 << 29);
            p.rot_y  = rand_small(1 << 29);
            p.rot_z  = rand_small(1 << 29);
        end else begin
            p.vel_x  = $urandom;
            p.vel_y  = $urandom;
            p.vel_z  = $urandom;
            p.kick_x = $urandom;
            p.kick_y = $urandom;
            p.kick_z = $urandom;
            p.rot_x  = $urandom;
            p.rot_y  = $urandom;
            p.rot_z  = $urandom;
        end
        return p;
    endfunction

    function automatic t_in_item make_particle(logic [31:0] pos, logic [31:0] vel,
                                               logic [31:0] kick, logic [31:0] rot);
        t_in_item p;
        p = '{pos, pos, pos, vel, vel, vel, kick, kick, kick, rot, rot, rot};
        return p;
    endfunction

    // field extremes, wrap, saturation and zero rotation
    task automatic test_extremes();
        t_in_item p;
        send_particle(make_particle(32'h0, 32'h0, 32'h0, 32'h0));
        send_particle(make_particle(32'hFFFF_FFFF, 32'h0400_0000, 32'h0, 32'h0));
        send_particle(make_particle(32'h0000_0010, 32'hFC00_0000, 32'h0, 32'h0));
        send_particle(make_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF));
        send_particle(make_particle(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_particle(make_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h4000_0000));
        p = make_particle(32'h1234_5678, 32'h0100_0000, 32'h0008_0000, 32'h0);
        p.rot_z = 32'h4000_0000;
        send_particle(p);
        p.vel_y = 32'hF000_0000;
        p.rot_x = 32'hC000_0000;
        p.kick_z = 32'h8000_0000;
        send_particle(p);
    endtask

    // speed limit at zero, at full scale, and step extremes
    task automatic test_limit_extremes();
        wait_drained();
        write_cfg(CFG_SPEED_LIMIT, 32'h0);
        send_particle(make_particle(32'h0, 32'h0, 32'h0, 32'h0));
        send_particle(make_particle(32'h0, 32'h0000_0001, 32'h0, 32'h0));
        send_particle(make_particle(32'h5555_5555, 32'hC000_0000, 32'h1000, 32'h2000_0000));
        wait_drained();
        write_cfg(CFG_SPEED_LIMIT, 32'h7FFF_FFFF);
        write_cfg(CFG_POSITION_STEP, 32'hFFFF_FFFF);
        send_particle(make_particle(32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0, 32'h0));
        send_particle(make_particle(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h1));
        send_particle(make_particle(32'h0, 32'h4000_0000, 32'h0, 32'h7FFF_FFFF));
        wait_drained();
        write_cfg(CFG_POSITION_STEP, 32'h0);
        send_particle(make_particle(32'h0ABC_DEF0, 32'h2000_0000, 32'h0, 32'h0));
        // top bit of a speed limit write falls outside the register
        wait_drained();
        write_cfg(CFG_SPEED_LIMIT, 32'h8000_0000 | SPEED_LIMIT_RST);
        write_cfg(CFG_POSITION_STEP, POSITION_STEP_RST);
        send_particle(make_particle(32'h0, 32'h0800_0000, 32'h0, 32'h0));
    endtask

    // random particles under a few register settings, one idling pattern
    task automatic test_random_stream(int in_pct, int out_pct);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        for (int k = 0; k < 4; k++) begin
            wait_drained();
            case (k)
                0: begin
                    write_cfg(CFG_SPEED_LIMIT, SPEED_LIMIT_RST);
                    write_cfg(CFG_POSITION_STEP, POSITION_STEP_RST);
                end
                1: begin
                    write_cfg(CFG_SPEED_LIMIT, $urandom);
                    write_cfg(CFG_POSITION_STEP, $urandom);
                end
                2: begin
                    write_cfg(CFG_SPEED_LIMIT, $urandom_range(32'h1000_0000));
                    write_cfg(CFG_POSITION_STEP, 32'hFFFF_FFFF);
                end
                default: begin
                    write_cfg(CFG_SPEED_LIMIT, 32'h7FFF_FFFF);
                    write_cfg(CFG_POSITION_STEP, $urandom_range(32'h0010_0000));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_RUN / 4; n++) begin
                send_particle(rand_particle());
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_SPEED_LIMIT;
        i_cfg_data   = '0;
        in_idle_pct  = 11;
        out_idle_pct = 65;
        n_errors     = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_clipped    = 0;
        n_cfg        = 0;
        quiet_cycles = 0;
        limit_q      = SPEED_LIMIT_RST;
        step_q       = POSITION_STEP_RST;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_limit_extremes();
        test_random_stream(11, 65);
        test_random_stream(65, 11);
        test_random_stream(0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("pushed %0d particles, %0d checked, %0d speed clipped, %0d register writes",
                 n_sent, n_checked, n_clipped, n_cfg);
        if (n_errors == 0 && pushed_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, pushed_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
